// ----- rtl/sbeu_pkg.sv -----
// ----------------------------------------------------------------------------
// sbeu_pkg
// Shared types and constants of the stack bytecode execute unit.
// ----------------------------------------------------------------------------
package sbeu_pkg;

	localparam int STACK_DEPTH_DEF = 1024;
	localparam int VAR_COUNT_DEF   = 256;
	localparam int DATA_WIDTH_DEF  = 32;

	localparam int CMD_W   = 4;
	localparam int IMM_W   = 32;
	localparam int IDX_W   = 8;
	localparam int TGT_W   = 16;
	localparam int PRINT_W = 32;
	localparam int FAULT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		OP_PUSHIMM  = 4'd0,
		OP_LDVAR    = 4'd1,
		OP_STVAR    = 4'd2,
		OP_INCV     = 4'd3,
		OP_MUL      = 4'd4,
		OP_DIV      = 4'd5,
		OP_ADD      = 4'd6,
		OP_SUB      = 4'd7,
		OP_CMP      = 4'd8,
		OP_JMP      = 4'd9,
		OP_JEQ      = 4'd10,
		OP_JNE      = 4'd11,
		OP_JG       = 4'd12,
		OP_PRINT    = 4'd13,
		OP_HALT     = 4'd14,
		OP_NONE     = 4'd15
	} op_t;

	typedef enum logic [FAULT_W-1:0] {
		FLT_NONE  = 2'd0,
		FLT_OVER  = 2'd1,
		FLT_UNDER = 2'd2,
		FLT_DIVZ  = 2'd3
	} fault_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture item
		logic rd_top;    // read stack[count-1]
		logic rd_next;   // read stack[count-2]
		logic rd_var;    // read variable
		logic lat_b;     // latch read data into b
		logic lat_a;     // latch read data into a
		logic lat_v;     // latch variable read data
		logic div_start;
		logic mul_start;
		logic exec;      // commit state change and build result
	} sbeu_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mul_done;
	} sbeu_sts_t;

endpackage

// ----- rtl/stack_bytecode_execute_unit.sv -----
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit
// Executes one decoded stack-machine instruction per item.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata, low bit first)
// s_axis   in   cmd[3:0] imm_value[35:4] var_index[43:36] jump_target[59:44]
// m_axis   out  branch_taken[0] next_target[16:1] print_valid[17]
//               print_value[49:18] halted[50] fault[52:51]
// Each item steps through read, read, latch, commit; mul and div wait in between
// for the multiplier or the bit-serial divider. The stack memory's single
// read port splits the reads. Reset leaves the stack empty, variables zero.
// The result register takes the next item only once the last one is read.
module stack_bytecode_execute_unit
	import sbeu_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VAR_COUNT   = VAR_COUNT_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // cmd, imm_value, var_index, jump_target
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // branch_taken, next_target, print_valid,
	                                   // print_value, halted, fault
);

	sbeu_cmd_t          cmd;
	sbeu_sts_t          sts;
	op_t                op;
	logic               busy, in_fire, out_free;
	logic               r_taken, r_pvalid, r_halt;
	logic [TGT_W-1:0]   r_tgt;
	logic [PRINT_W-1:0] r_pval;
	logic [FAULT_W-1:0] r_fault;
	logic [52:0]        res_q;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	sbeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.op       (op),
		.out_free (out_free),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	sbeu_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VAR_COUNT   (VAR_COUNT),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_cmd     (s_axis_tdata[3:0]),
		.in_imm     (s_axis_tdata[35:4]),
		.in_idx     (s_axis_tdata[43:36]),
		.in_tgt     (s_axis_tdata[59:44]),
		.op         (op),
		.sts        (sts),
		.res_taken  (r_taken),
		.res_target (r_tgt),
		.res_pvalid (r_pvalid),
		.res_pvalue (r_pval),
		.res_halt   (r_halt),
		.res_fault  (r_fault)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (cmd.exec) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) res_q <= {r_fault, r_halt, r_pval, r_pvalid, r_tgt, r_taken};
	end

	assign m_axis_tdata = {3'b000, res_q};

endmodule

// ----- rtl/sbeu_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbeu_ctrl
// Sequencer: steps each item through memory reads, arithmetic and commit.
// ----------------------------------------------------------------------------
module sbeu_ctrl
	import sbeu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  op_t       op,
	input  logic      out_free,
	input  sbeu_sts_t sts,
	output logic      busy,
	output sbeu_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_LAT, S_WAIT, S_EXEC
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		unique case (state_q)
			S_RD1: begin
				cmd.rd_top = 1'b1;
				cmd.rd_var = 1'b1;
			end
			S_RD2: begin
				cmd.rd_next = 1'b1;
				cmd.lat_b   = 1'b1;
				cmd.lat_v   = 1'b1;
			end
			S_LAT: begin
				cmd.lat_a     = 1'b1;
				cmd.div_start = (op == OP_DIV);
				cmd.mul_start = (op == OP_MUL);
			end
			S_EXEC: cmd.exec = out_free;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) state_q <= S_RD1;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_LAT;
				S_LAT:  state_q <= (op == OP_DIV || op == OP_MUL) ? S_WAIT : S_EXEC;
				S_WAIT: if ((op == OP_DIV && sts.div_done) || (op == OP_MUL && sts.mul_done))
					state_q <= S_EXEC;
				S_EXEC: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sbeu_div.sv -----
// ----------------------------------------------------------------------------
// sbeu_div
// Signed restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sbeu_div
	import sbeu_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] q
);

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] quo_q, den_q;
	logic [DATA_WIDTH:0]   rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q, run_q;
	logic [DATA_WIDTH:0]   shl, sub;

	assign shl = {rem_q[DATA_WIDTH-1:0], quo_q[DATA_WIDTH-1]};
	assign sub = shl - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DATA_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= a[DATA_WIDTH-1] ? -a : a;
			den_q <= b[DATA_WIDTH-1] ? -b : b;
			neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			rem_q <= '0;
		end else if (run_q) begin
			if (!sub[DATA_WIDTH]) begin
				rem_q <= sub;
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shl;
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign q = neg_q ? -quo_q : quo_q;

endmodule

// ----- rtl/sbeu_dpath.sv -----
// ----------------------------------------------------------------------------
// sbeu_dpath
// Operand stack, variable file, compare flags, multiplier and result build.
// ----------------------------------------------------------------------------
module sbeu_dpath
	import sbeu_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VAR_COUNT   = VAR_COUNT_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbeu_cmd_t             cmd,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [IMM_W-1:0]      in_imm,
	input  logic [IDX_W-1:0]      in_idx,
	input  logic [TGT_W-1:0]      in_tgt,
	output op_t                   op,
	output sbeu_sts_t             sts,
	output logic                  res_taken,
	output logic [TGT_W-1:0]      res_target,
	output logic                  res_pvalid,
	output logic [PRINT_W-1:0]    res_pvalue,
	output logic                  res_halt,
	output logic [FAULT_W-1:0]    res_fault
);

	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	logic [DATA_WIDTH-1:0] stk_mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0]  var_vld_q;

	op_t                   op_q;
	logic [IMM_W-1:0]      imm_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TGT_W-1:0]      tgt_q;
	logic [SCW-1:0]        cnt_q;
	logic                  cz_q, cg_q;
	logic [DATA_WIDTH-1:0] stk_rd_q, var_rd_q, a_q, b_q, v_q, prod_q;
	logic                  var_hit_q, mul_run_q, mul_done_q;
	logic [SAW-1:0]        rd_addr, wr_addr;
	logic                  idx_ok;
	logic [VAW-1:0]        vaddr;
	logic [DATA_WIDTH-1:0] div_q, vread, push_v, alu_r, var_wv;
	logic                  div_done, div_skip;
	logic                  need2, fault_over, fault_under, fault_dz;
	logic                  stk_we, var_we;

	assign op     = op_q;
	assign idx_ok = ({{(32-IDX_W){1'b0}}, idx_q} < 32'(VAR_COUNT));
	assign vaddr  = VAW'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_cmd);
			imm_q <= in_imm;
			idx_q <= in_idx;
			tgt_q <= in_tgt;
		end
	end

	assign rd_addr = cmd.rd_next ? SAW'(cnt_q - SCW'(2)) : SAW'(cnt_q - SCW'(1));

	always_ff @(posedge clk) begin
		if (cmd.rd_top || cmd.rd_next) stk_rd_q <= stk_mem[rd_addr];
		if (stk_we) stk_mem[wr_addr] <= (op_q == OP_PUSHIMM || op_q == OP_LDVAR)
			? push_v : alu_r;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_var) var_rd_q <= var_mem[vaddr];
		if (var_we) var_mem[vaddr] <= var_wv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q <= '0;
			var_hit_q <= 1'b0;
		end else begin
			if (cmd.rd_var) var_hit_q <= idx_ok && var_vld_q[vaddr];
			if (var_we) var_vld_q[vaddr] <= 1'b1;
		end
	end

	assign vread = var_hit_q ? var_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.lat_b) b_q <= stk_rd_q;
		if (cmd.lat_v) v_q <= vread;
		if (cmd.lat_a) a_q <= stk_rd_q;
		if (mul_run_q) prod_q <= DATA_WIDTH'(a_q * b_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q  <= 1'b0;
			mul_done_q <= 1'b0;
		end else begin
			mul_run_q  <= cmd.mul_start;
			mul_done_q <= mul_run_q;
		end
	end

	// zero divisor or short stack: divider never starts, report done at once
	assign div_skip = cnt_q < SCW'(2) || b_q == '0;

	sbeu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start && !div_skip),
		.a      (stk_rd_q),
		.b      (b_q),
		.done   (div_done),
		.q      (div_q)
	);

	assign sts.div_done = div_done || div_skip;
	assign sts.mul_done = mul_done_q;

	assign push_v = (op_q == OP_PUSHIMM) ? DATA_WIDTH'($signed(imm_q)) : v_q;

	always_comb begin
		case (op_q)
			OP_MUL:  alu_r = prod_q;
			OP_DIV:  alu_r = div_q;
			OP_ADD:  alu_r = a_q + b_q;
			default: alu_r = a_q - b_q;
		endcase
	end

	assign need2 = (op_q == OP_MUL || op_q == OP_DIV || op_q == OP_ADD ||
		op_q == OP_SUB || op_q == OP_CMP);
	assign fault_over  = (op_q == OP_PUSHIMM || op_q == OP_LDVAR) &&
		cnt_q == SCW'(STACK_DEPTH);
	assign fault_under = (op_q == OP_STVAR && cnt_q == '0) || (need2 && cnt_q < SCW'(2));
	assign fault_dz    = op_q == OP_DIV && !fault_under && b_q == '0;

	assign stk_we = cmd.exec && !fault_over && !fault_under && !fault_dz &&
		(op_q == OP_PUSHIMM || op_q == OP_LDVAR || (need2 && op_q != OP_CMP));
	assign wr_addr = (op_q == OP_PUSHIMM || op_q == OP_LDVAR) ? SAW'(cnt_q)
		: SAW'(cnt_q - SCW'(2));

	assign var_we = cmd.exec && idx_ok &&
		((op_q == OP_STVAR && !fault_under) || op_q == OP_INCV);
	assign var_wv = (op_q == OP_INCV) ? v_q + 1'b1 : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cz_q  <= 1'b1;
			cg_q  <= 1'b0;
		end else if (cmd.exec && !fault_over && !fault_under && !fault_dz) begin
			case (op_q)
				OP_PUSHIMM, OP_LDVAR: cnt_q <= cnt_q + 1'b1;
				OP_STVAR: cnt_q <= cnt_q - 1'b1;
				OP_MUL, OP_DIV, OP_ADD, OP_SUB: cnt_q <= cnt_q - 1'b1;
				OP_CMP: begin
					cnt_q <= cnt_q - SCW'(2);
					cz_q  <= a_q == b_q;
					cg_q  <= $signed(a_q) > $signed(b_q);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_taken = 1'b0;
		case (op_q)
			OP_JMP: res_taken = 1'b1;
			OP_JEQ: res_taken = cz_q;
			OP_JNE: res_taken = !cz_q;
			OP_JG:  res_taken = cg_q;
			default: ;
		endcase
	end

	assign res_target = res_taken ? tgt_q : '0;
	assign res_pvalid = op_q == OP_PRINT;
	assign res_pvalue = res_pvalid ? PRINT_W'($signed(v_q)) : '0;
	assign res_halt   = op_q == OP_HALT;
	assign res_fault  = fault_over ? FLT_OVER : fault_under ? FLT_UNDER
		: fault_dz ? FLT_DIVZ : FLT_NONE;

endmodule

// ----- rtl/sbeu_checker.sv -----
// ----------------------------------------------------------------------------
// sbeu_checker
// Port-level checks of the execute unit.
// ----------------------------------------------------------------------------
module sbeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too early");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $countones({m_axis_tdata[0], m_axis_tdata[17],
			m_axis_tdata[50], m_axis_tdata[52:51] != 2'b00}) <= 1)
		else $error("conflicting result flags");

endmodule

bind stack_bytecode_execute_unit sbeu_checker u_sbeu_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives instruction items into the stack execute unit with random stalls on
// both streams, predicts each result from its own stack, variable and compare
// state, and checks every result field by field in order.
// ----------------------------------------------------------------------------
module tb;
	import sbeu_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int NVAR  = VAR_COUNT_DEF;

	typedef struct packed {
		logic [15:0] jump_target;
		logic [7:0]  var_index;
		logic [31:0] imm_value;
		logic [3:0]  cmd;
	} instr_t;

	typedef struct packed {
		logic [1:0]  fault;
		logic        halted;
		logic [31:0] print_value;
		logic        print_valid;
		logic [15:0] next_target;
		logic        branch_taken;
	} outcome_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [55:0] m_axis_tdata;

	stack_bytecode_execute_unit dut (.*);

	instr_t   pending[$];
	outcome_t expected[$];
	logic [31:0] stk[DEPTH];
	int          depth_used;
	logic [31:0] vars[NVAR];
	logic        cz, cg;
	int errors = 0;
	int src_gap = 0, snk_gap = 0;
	bit calm = 0;
	bit driving = 0;

	initial forever #10 clk = ~clk;

	function automatic outcome_t execute(instr_t it);
		outcome_t r;
		logic [31:0] a, b, q;
		r = '0;
		case (op_t'(it.cmd))
			OP_PUSHIMM, OP_LDVAR: begin
				if (depth_used >= DEPTH) r.fault = FLT_OVER;
				else begin
					stk[depth_used] = (it.cmd == OP_PUSHIMM) ? it.imm_value : vars[it.var_index];
					depth_used++;
				end
			end
			OP_STVAR: begin
				if (depth_used < 1) r.fault = FLT_UNDER;
				else begin
					depth_used--;
					vars[it.var_index] = stk[depth_used];
				end
			end
			OP_INCV: vars[it.var_index] = vars[it.var_index] + 1;
			OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_CMP: begin
				if (depth_used < 2) r.fault = FLT_UNDER;
				else begin
					a = stk[depth_used-2];
					b = stk[depth_used-1];
					if (it.cmd == OP_DIV && b == 0) r.fault = FLT_DIVZ;
					else if (it.cmd == OP_CMP) begin
						cz = (a == b);
						cg = $signed(a) > $signed(b);
						depth_used -= 2;
					end else begin
						case (op_t'(it.cmd))
							OP_MUL: q = a * b;
							OP_DIV: begin
								q = (a[31] ? -a : a) / (b[31] ? -b : b);
								if (a[31] != b[31]) q = -q;
							end
							OP_ADD: q = a + b;
							default: q = a - b;
						endcase
						stk[depth_used-2] = q;
						depth_used--;
					end
				end
			end
			OP_JMP: r.branch_taken = 1;
			OP_JEQ: r.branch_taken = cz;
			OP_JNE: r.branch_taken = !cz;
			OP_JG: r.branch_taken = cg;
			OP_PRINT: begin
				r.print_valid = 1;
				r.print_value = vars[it.var_index];
			end
			OP_HALT: r.halted = 1;
			default: ;
		endcase
		if (r.branch_taken) r.next_target = it.jump_target;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 0;
			4: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic add(op_t op, logic [31:0] imm = 0, logic [7:0] idx = 0);
		instr_t it;
		it.cmd = op;
		it.imm_value = imm;
		it.var_index = idx;
		it.jump_target = 16'($urandom);
		pending.push_back(it);
	endtask

	bit sent;
	always @(posedge clk) begin
		sent <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected.push_back(execute(instr_t'(s_axis_tdata[59:0])));
		if (m_axis_tvalid && m_axis_tready) begin
			outcome_t got, exp;
			got = m_axis_tdata[52:0];
			if (expected.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp = expected.pop_front();
				if (got.branch_taken !== exp.branch_taken || got.next_target !== exp.next_target
					|| got.print_valid !== exp.print_valid
					|| got.print_value !== exp.print_value || got.halted !== exp.halted
					|| got.fault !== exp.fault) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp, got);
					errors++;
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && driving) begin
			if (!s_axis_tvalid || sent) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 0;
				end else if (pending.size() > 0) begin
					s_axis_tdata <= {4'b0, pending.pop_front()};
					s_axis_tvalid <= 1;
					if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 11);
				end else s_axis_tvalid <= 0;
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
				if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 11);
			end
		end
	end

	initial begin
		int k, n;
		depth_used = 0;
		cz = 1;
		cg = 0;
		foreach (vars[i]) vars[i] = 0;
		// directed
		add(OP_STVAR, 0, 3);
		add(OP_ADD);
		add(OP_PUSHIMM, 32'h8000_0000);
		add(OP_CMP);
		add(OP_PUSHIMM, 32'hffff_ffff);
		add(OP_DIV);
		add(OP_PUSHIMM, 0);
		add(OP_DIV);
		add(OP_STVAR, 0, 5);
		add(OP_STVAR, 0, 255);
		add(OP_PRINT, 0, 255);
		add(OP_INCV, 0, 5);
		add(OP_LDVAR, 0, 5);
		add(OP_PUSHIMM, 32'h7fff_ffff);
		add(OP_MUL);
		add(OP_PUSHIMM, -7);
		add(OP_PUSHIMM, 2);
		add(OP_DIV);
		add(OP_PUSHIMM, 32'h8000_0000);
		add(OP_CMP);
		add(OP_JG); add(OP_JEQ); add(OP_JNE); add(OP_JMP);
		add(OP_HALT); add(OP_NONE); add(OP_SUB);
		// random
		for (n = 0; n < 373; ) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				add(OP_PUSHIMM, rand_word(), 8'($urandom));
				add($urandom_range(0, 1) ? OP_PUSHIMM : OP_LDVAR, rand_word(), 8'($urandom));
				add(op_t'($urandom_range(OP_MUL, OP_CMP)), 0, 8'($urandom));
				add(op_t'($urandom_range(OP_JMP, OP_JG)), 0, 8'($urandom));
				add(op_t'($urandom_range(0, 1) ? OP_STVAR : OP_PRINT), 0, 8'($urandom));
				n += 5;
			end else begin
				add(op_t'($urandom_range(0, 15)), rand_word(), 8'($urandom));
				n++;
			end
		end
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1;
		driving = 1;
		wait (pending.size() < 60);
		calm = 1;
		wait (pending.size() == 0 && !s_axis_tvalid);
		wait (expected.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/sbeu_pkg.sv
rtl/sbeu_ctrl.sv
rtl/sbeu_div.sv
rtl/sbeu_dpath.sv
rtl/stack_bytecode_execute_unit.sv
rtl/sbeu_checker.sv
tb/tb.sv
